// ===== design/solid_angle_energy_weight_macros.svh =====
// Assertion macros for the solid angle energy weight block.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SOLID_ANGLE_ENERGY_WEIGHT_MACROS_SVH
`define SOLID_ANGLE_ENERGY_WEIGHT_MACROS_SVH

// Plain property, sampled on clk, off while in reset
`define SAEW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define SAEW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/saew_pkg.sv =====
// Package for the solid angle energy weight block: widths, register codes,
// carried sideband types, the CORDIC arctangent table and a leading-one search.
`timescale 1ns / 1ps

package saew_pkg;

  localparam int LEN_W    = 20;          // lengths in micrometres
  localparam int EN_W     = 20;          // energy in electronvolts
  localparam int FR_W     = 16;          // fraction, Q0.16
  localparam int D_W      = LEN_W + 2;   // signed thickness -/+ 2*depth
  localparam int AD_W     = LEN_W + 1;   // |D|, always below 2^21
  localparam int Q_W      = 2 * AD_W + 1;
  localparam int V_W      = 62;          // normalized radicand
  localparam int S_W      = 31;          // square root
  localparam int REM_W    = S_W + 2;     // root remainder
  localparam int K_W      = 5;
  localparam int MN_W     = AD_W + S_W;  // vector components before normalizing
  localparam int MSB_W    = 6;
  localparam int NORM_POS = 49;          // leading one lands on this bit
  localparam int C_W      = MN_W + 2;    // CORDIC x/y, signed, with growth
  localparam int Z_W      = 33;          // CORDIC angle accumulator, signed
  localparam int STEPS    = 31;
  localparam int Z_FULL   = 30;          // angle unit: 2^30 is one half turn / 2
  localparam int CFG_IDX_W = 2;

  localparam logic [FR_W-1:0] FRAC_HALF  = FR_W'(1) << (FR_W - 1);
  localparam logic [EN_W-1:0] WEIGHT_MAX = EN_W'(1) << (EN_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_X  = 2'd0,
    REG_PIXEL_Y  = 2'd1,
    REG_READ_OPP = 2'd2
  } cfg_reg_t;

  // Travels with every hit to the end of the pipe
  typedef struct packed {
    logic [EN_W-1:0] energy;
    logic            spec;       // result fixed by a special case
    logic [FR_W-1:0] spec_frac;
  } side_t;

  // Front end to root unit to scaler
  typedef struct packed {
    side_t            side;
    logic [AD_W-1:0]  ad;
    logic [MN_W-1:0]  nval;
  } carry_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [Z_W-1:0] atan_lut(input int idx);
    logic [31:0] t;
    case (idx)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      24: t = 32'h00000029;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      28: t = 32'h00000003;
      29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = '0;
    endcase
    return Z_W'(t);
  endfunction

  // Position of the highest set bit, zero for an all-zero word
  function automatic logic [MSB_W-1:0] msb_pos(input logic [MN_W-1:0] v);
    logic [MSB_W-1:0] p;
    p = '0;
    for (int i = 0; i < MN_W; i++) begin
      if (v[i]) p = MSB_W'(i);
    end
    return p;
  endfunction

endpackage

// ===== design/saew_front.sv =====
// Front end: distance to the readout face, special cases, squares, radicand
// and its even normalizing shift. Uses saew_pkg.
`timescale 1ns / 1ps

module saew_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [saew_pkg::EN_W-1:0]    energy,
  input  logic signed [saew_pkg::LEN_W-1:0] depth,
  input  logic [saew_pkg::LEN_W-1:0]   thick,
  input  logic [saew_pkg::LEN_W-1:0]   size_x,
  input  logic [saew_pkg::LEN_W-1:0]   size_y,
  input  logic                         opp,
  output logic                         out_valid,
  output logic [saew_pkg::V_W-1:0]     out_v,
  output saew_pkg::carry_t             out_carry
);

  // Stage 1: signed distance, its magnitude, special cases
  logic signed [saew_pkg::D_W-1:0] thick_s, dep2_s, d_s;
  logic [saew_pkg::D_W-1:0]        d_abs;
  saew_pkg::side_t                 side1_nxt;

  assign thick_s = {2'b00, thick};
  assign dep2_s  = {depth[saew_pkg::LEN_W-1], depth, 1'b0};
  assign d_s     = opp ? (thick_s + dep2_s) : (thick_s - dep2_s);
  assign d_abs   = d_s[saew_pkg::D_W-1] ? (~d_s + 1'b1) : d_s;

  always_comb begin
    side1_nxt.energy    = energy;
    side1_nxt.spec      = 1'b0;
    side1_nxt.spec_frac = '0;
    if (d_s == '0) begin
      // hit on the readout face
      side1_nxt.spec      = 1'b1;
      side1_nxt.spec_frac = saew_pkg::FRAC_HALF;
    end else if (size_x == '0 || size_y == '0) begin
      side1_nxt.spec = 1'b1;
    end
  end

  logic                        s1_vld_r;
  logic [saew_pkg::AD_W-1:0]   s1_ad_r;
  saew_pkg::side_t             s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ad_r   <= d_abs[saew_pkg::AD_W-1:0];
      s1_side_r <= side1_nxt;
    end
  end

  // Stage 2: the four products
  logic                          s2_vld_r;
  logic [2*saew_pkg::AD_W-1:0]   s2_dd_r;
  logic [2*saew_pkg::LEN_W-1:0]  s2_xx_r, s2_yy_r, s2_xy_r;
  logic [saew_pkg::AD_W-1:0]     s2_ad_r;
  saew_pkg::side_t               s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dd_r   <= s1_ad_r * s1_ad_r;
      s2_xx_r   <= size_x * size_x;
      s2_yy_r   <= size_y * size_y;
      s2_xy_r   <= size_x * size_y;
      s2_ad_r   <= s1_ad_r;
      s2_side_r <= s1_side_r;
    end
  end

  // Stage 3: Q = D^2 + X^2 + Y^2
  logic                          s3_vld_r;
  logic [saew_pkg::Q_W-1:0]      s3_q_r;
  logic [2*saew_pkg::LEN_W-1:0]  s3_xy_r;
  logic [saew_pkg::AD_W-1:0]     s3_ad_r;
  saew_pkg::side_t               s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_q_r    <= saew_pkg::Q_W'(s2_dd_r) + saew_pkg::Q_W'(s2_xx_r)
                 + saew_pkg::Q_W'(s2_yy_r);
      s3_xy_r   <= s2_xy_r;
      s3_ad_r   <= s2_ad_r;
      s3_side_r <= s2_side_r;
    end
  end

  // Stage 4: k = smallest shift that puts Q*4^k at or above 2^60
  logic [saew_pkg::MSB_W-1:0] q_msb;
  logic [saew_pkg::MSB_W:0]   k_twice;

  assign q_msb   = saew_pkg::msb_pos(saew_pkg::MN_W'(s3_q_r));
  assign k_twice = (saew_pkg::MSB_W+1)'(61) - {1'b0, q_msb};

  logic                          s4_vld_r;
  logic [saew_pkg::Q_W-1:0]      s4_q_r;
  logic [saew_pkg::K_W-1:0]      s4_k_r;
  logic [2*saew_pkg::LEN_W-1:0]  s4_xy_r;
  logic [saew_pkg::AD_W-1:0]     s4_ad_r;
  saew_pkg::side_t               s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (en) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q_r    <= s3_q_r;
      s4_k_r    <= k_twice[saew_pkg::K_W:1];
      s4_xy_r   <= s3_xy_r;
      s4_ad_r   <= s3_ad_r;
      s4_side_r <= s3_side_r;
    end
  end

  // Stage 5: radicand Q*4^k and N = X*Y*2^k
  logic                        s5_vld_r;
  logic [saew_pkg::V_W-1:0]    s5_v_r;
  saew_pkg::carry_t            s5_carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (en) s5_vld_r <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_v_r          <= saew_pkg::V_W'(s4_q_r) << {s4_k_r, 1'b0};
      s5_carry_r.nval <= saew_pkg::MN_W'(s4_xy_r) << s4_k_r;
      s5_carry_r.ad   <= s4_ad_r;
      s5_carry_r.side <= s4_side_r;
    end
  end

  assign out_valid = s5_vld_r;
  assign out_v     = s5_v_r;
  assign out_carry = s5_carry_r;

endmodule

// ===== design/saew_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, restoring form.
// Uses saew_pkg.
`timescale 1ns / 1ps

module saew_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [saew_pkg::V_W-1:0]  in_v,
  input  saew_pkg::carry_t          in_carry,
  output logic                      out_valid,
  output logic [saew_pkg::S_W-1:0]  out_root,
  output saew_pkg::carry_t          out_carry
);

  logic                          vld_r   [saew_pkg::STEPS];
  logic [saew_pkg::REM_W-1:0]    rem_r   [saew_pkg::STEPS];
  logic [saew_pkg::S_W-1:0]      root_r  [saew_pkg::STEPS];
  logic [saew_pkg::V_W-1:0]      v_r     [saew_pkg::STEPS];
  saew_pkg::carry_t              carry_r [saew_pkg::STEPS];

  for (genvar j = 0; j < saew_pkg::STEPS; j++) begin : g_step
    logic                        vld_in;
    logic [saew_pkg::REM_W-1:0]  rem_in;
    logic [saew_pkg::S_W-1:0]    root_in;
    logic [saew_pkg::V_W-1:0]    v_in;
    saew_pkg::carry_t            c_in;
    logic [saew_pkg::REM_W+1:0]  rem_sh, trial, diff;
    logic                        ge;

    if (j == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = in_v;
      assign c_in    = in_carry;
    end else begin : g_tail
      assign vld_in  = vld_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign v_in    = v_r[j-1];
      assign c_in    = carry_r[j-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_in, v_in[saew_pkg::V_W-1-2*j -: 2]};
    assign trial  = (saew_pkg::REM_W+2)'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j] <= 1'b0;
      else if (en) vld_r[j] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]   <= ge ? diff[saew_pkg::REM_W-1:0] : rem_sh[saew_pkg::REM_W-1:0];
        root_r[j]  <= {root_in[saew_pkg::S_W-2:0], ge};
        v_r[j]     <= v_in;
        carry_r[j] <= c_in;
      end
    end
  end

  assign out_valid = vld_r[saew_pkg::STEPS-1];
  assign out_root  = root_r[saew_pkg::STEPS-1];
  assign out_carry = carry_r[saew_pkg::STEPS-1];

endmodule

// ===== design/saew_scale.sv =====
// Builds the CORDIC start vector M = |D|*S, N, and normalizes both together
// so the larger has its leading one at bit 49. Uses saew_pkg.
`timescale 1ns / 1ps

module saew_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [saew_pkg::S_W-1:0]   in_root,
  input  saew_pkg::carry_t           in_carry,
  output logic                       out_valid,
  output logic [saew_pkg::MN_W-1:0]  out_x,
  output logic [saew_pkg::MN_W-1:0]  out_y,
  output saew_pkg::side_t            out_side
);

  // Stage A: M = |D| * S
  logic                        a_vld_r;
  logic [saew_pkg::MN_W-1:0]   a_m_r, a_n_r;
  saew_pkg::side_t             a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m_r    <= in_carry.ad * in_root;
      a_n_r    <= in_carry.nval;
      a_side_r <= in_carry.side;
    end
  end

  // Stage B: leading one of the larger component
  logic [saew_pkg::MN_W-1:0] big;
  assign big = (a_m_r > a_n_r) ? a_m_r : a_n_r;

  logic                        b_vld_r;
  logic [saew_pkg::MN_W-1:0]   b_m_r, b_n_r;
  logic [saew_pkg::MSB_W-1:0]  b_p_r;
  saew_pkg::side_t             b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_m_r    <= a_m_r;
      b_n_r    <= a_n_r;
      b_p_r    <= saew_pkg::msb_pos(big);
      b_side_r <= a_side_r;
    end
  end

  // Stage C: common shift, right or left
  localparam logic [saew_pkg::MSB_W-1:0] NORM = saew_pkg::MSB_W'(saew_pkg::NORM_POS);
  logic                        down;
  logic [saew_pkg::MSB_W-1:0]  amt;

  assign down = (b_p_r >= NORM);
  assign amt  = down ? (b_p_r - NORM) : (NORM - b_p_r);

  logic                        c_vld_r;
  logic [saew_pkg::MN_W-1:0]   c_x_r, c_y_r;
  saew_pkg::side_t             c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x_r    <= down ? (b_m_r >> amt) : (b_m_r << amt);
      c_y_r    <= down ? (b_n_r >> amt) : (b_n_r << amt);
      c_side_r <= b_side_r;
    end
  end

  assign out_valid = c_vld_r;
  assign out_x     = c_x_r;
  assign out_y     = c_y_r;
  assign out_side  = c_side_r;

endmodule

// ===== design/saew_cordic.sv =====
// Pipelined CORDIC in vectoring mode, one micro-rotation per stage; returns
// the angle of (x, y) with 2^31 standing for pi. Uses saew_pkg.
`timescale 1ns / 1ps

module saew_cordic (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [saew_pkg::MN_W-1:0]  in_x,
  input  logic [saew_pkg::MN_W-1:0]  in_y,
  input  saew_pkg::side_t            in_side,
  output logic                       out_valid,
  output logic signed [saew_pkg::Z_W-1:0] out_z,
  output saew_pkg::side_t            out_side
);

  logic                               vld_r  [saew_pkg::STEPS];
  logic signed [saew_pkg::C_W-1:0]    x_r    [saew_pkg::STEPS];
  logic signed [saew_pkg::C_W-1:0]    y_r    [saew_pkg::STEPS];
  logic signed [saew_pkg::Z_W-1:0]    z_r    [saew_pkg::STEPS];
  saew_pkg::side_t                    side_r [saew_pkg::STEPS];

  for (genvar i = 0; i < saew_pkg::STEPS; i++) begin : g_rot
    localparam logic signed [saew_pkg::Z_W-1:0] ANG = saew_pkg::atan_lut(i);
    logic                             vld_in;
    logic signed [saew_pkg::C_W-1:0]  x_in, y_in, dx, dy, y_neg;
    logic signed [saew_pkg::Z_W-1:0]  z_in;
    saew_pkg::side_t                  s_in;
    logic                             y_lo;

    if (i == 0) begin : g_head
      assign vld_in = in_valid;
      assign x_in   = {2'b00, in_x};
      assign y_in   = {2'b00, in_y};
      assign z_in   = '0;
      assign s_in   = in_side;
    end else begin : g_tail
      assign vld_in = vld_r[i-1];
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign s_in   = side_r[i-1];
    end

    // shifts truncate toward zero; x stays positive
    assign y_lo  = y_in[saew_pkg::C_W-1];
    assign y_neg = -y_in;
    assign dx    = y_lo ? -(y_neg >>> i) : (y_in >>> i);
    assign dy    = x_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (en) vld_r[i] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= y_lo ? (x_in - dx) : (x_in + dx);
        y_r[i]    <= y_lo ? (y_in + dy) : (y_in - dy);
        z_r[i]    <= y_lo ? (z_in - ANG) : (z_in + ANG);
        side_r[i] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[saew_pkg::STEPS-1];
  assign out_z     = z_r[saew_pkg::STEPS-1];
  assign out_side  = side_r[saew_pkg::STEPS-1];

endmodule

// ===== design/solid_angle_energy_weight.sv =====
// Top level of the solid angle energy weight block: configuration registers,
// the pipeline of saew_front, saew_isqrt, saew_scale, saew_cordic, and the output stage.
// Depends on saew_pkg and solid_angle_energy_weight_macros.svh.
//
// Use: each input request carries a hit's deposited energy, local depth and
// crystal thickness; each yields exactly one result request with the solid
// angle fraction (Q0.16, at most one half) and the energy weighted by it.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// pixel sizes and the readout sense; cfg_ready is always high, and writes are
// meant for times when no hit is in flight. Unknown indexes are dropped.
// From input accept to out_valid a hit passes 5 front-end stages,
// 31 square-root stages (one root bit each), 3 scaling stages, 31 CORDIC
// stages (one rotation each), one fraction stage and the output register.
// Throughput is one hit per cycle while no stall holds, set by the fully pipelined datapath.
// Reset clears the valid bits and sets all configuration registers to zero.
// While out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "solid_angle_energy_weight_macros.svh"

module solid_angle_energy_weight (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [saew_pkg::EN_W-1:0]       in_deposited_energy,
  input  logic signed [saew_pkg::LEN_W-1:0] in_local_depth,
  input  logic [saew_pkg::LEN_W-1:0]      in_crystal_thickness,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [saew_pkg::EN_W-1:0]       out_weighted_energy,
  output logic [saew_pkg::FR_W-1:0]       out_angle_fraction,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [saew_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [saew_pkg::LEN_W-1:0]      cfg_data
);

  // Configuration registers
  logic [saew_pkg::LEN_W-1:0] pixel_x_r, pixel_y_r;
  logic                       read_opp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_x_r  <= '0;
      pixel_y_r  <= '0;
      read_opp_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (saew_pkg::cfg_reg_t'(cfg_index))
        saew_pkg::REG_PIXEL_X:  pixel_x_r  <= cfg_data;
        saew_pkg::REG_PIXEL_Y:  pixel_y_r  <= cfg_data;
        saew_pkg::REG_READ_OPP: read_opp_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Global advance: freeze everything while a result waits
  logic out_valid_r;
  logic en;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Datapath
  logic                        fr_vld;
  logic [saew_pkg::V_W-1:0]    fr_v;
  saew_pkg::carry_t            fr_carry;
  logic                        sq_vld;
  logic [saew_pkg::S_W-1:0]    sq_root;
  saew_pkg::carry_t            sq_carry;
  logic                        sc_vld;
  logic [saew_pkg::MN_W-1:0]   sc_x, sc_y;
  saew_pkg::side_t             sc_side;
  logic                        co_vld;
  logic signed [saew_pkg::Z_W-1:0] co_z;
  saew_pkg::side_t             co_side;

  saew_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && !in_stall),
    .energy    (in_deposited_energy),
    .depth     (in_local_depth),
    .thick     (in_crystal_thickness),
    .size_x    (pixel_x_r),
    .size_y    (pixel_y_r),
    .opp       (read_opp_r),
    .out_valid (fr_vld),
    .out_v     (fr_v),
    .out_carry (fr_carry)
  );

  saew_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_vld),
    .in_v      (fr_v),
    .in_carry  (fr_carry),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_carry (sq_carry)
  );

  saew_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_root   (sq_root),
    .in_carry  (sq_carry),
    .out_valid (sc_vld),
    .out_x     (sc_x),
    .out_y     (sc_y),
    .out_side  (sc_side)
  );

  saew_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sc_vld),
    .in_x      (sc_x),
    .in_y      (sc_y),
    .in_side   (sc_side),
    .out_valid (co_vld),
    .out_z     (co_z),
    .out_side  (co_side)
  );

  // Fraction stage: clamp angle, round to Q0.16, apply special cases
  localparam logic [saew_pkg::Z_W-2:0] Z_MAX  = (saew_pkg::Z_W-1)'(1) << saew_pkg::Z_FULL;
  localparam logic [saew_pkg::Z_W-2:0] Z_RND  =
    (saew_pkg::Z_W-1)'(1) << (saew_pkg::Z_FULL - saew_pkg::FR_W);

  logic [saew_pkg::Z_W-2:0] z_clip, z_sum;
  logic [saew_pkg::FR_W-1:0] frac_raw, frac_nxt;

  always_comb begin
    if (co_z[saew_pkg::Z_W-1]) z_clip = '0;
    else if (co_z[saew_pkg::Z_W-2:0] > Z_MAX) z_clip = Z_MAX;
    else z_clip = co_z[saew_pkg::Z_W-2:0];
    z_sum    = z_clip + Z_RND;
    frac_raw = z_sum[saew_pkg::Z_FULL -: saew_pkg::FR_W];
    if (co_side.spec) frac_nxt = co_side.spec_frac;
    else if (frac_raw > saew_pkg::FRAC_HALF) frac_nxt = saew_pkg::FRAC_HALF;
    else frac_nxt = frac_raw;
  end

  logic                       fs_vld_r;
  logic [saew_pkg::FR_W-1:0]  fs_frac_r;
  logic [saew_pkg::EN_W-1:0]  fs_energy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) fs_vld_r <= 1'b0;
    else if (en) fs_vld_r <= co_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs_frac_r   <= frac_nxt;
      fs_energy_r <= co_side.energy;
    end
  end

  // Output register: weighted energy, rounded
  localparam int P_W = saew_pkg::EN_W + saew_pkg::FR_W;
  logic [P_W-1:0] wsum;

  assign wsum = P_W'(fs_energy_r) * P_W'(fs_frac_r) + (P_W'(1) << (saew_pkg::FR_W - 1));

  logic [saew_pkg::EN_W-1:0] out_weighted_energy_r;
  logic [saew_pkg::FR_W-1:0] out_angle_fraction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= fs_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_weighted_energy_r <= wsum[saew_pkg::FR_W +: saew_pkg::EN_W];
      out_angle_fraction_r  <= fs_frac_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_weighted_energy = out_weighted_energy_r;
  assign out_angle_fraction  = out_angle_fraction_r;

  // Checks
  `SAEW_ASSERT_IMP(a_frac_half, out_valid_r, out_angle_fraction_r <= saew_pkg::FRAC_HALF, "fraction above one half")
  `SAEW_ASSERT_IMP(a_weight_max, out_valid_r, out_weighted_energy_r <= saew_pkg::WEIGHT_MAX, "weighted energy above half scale")
  `SAEW_ASSERT_IMP(a_zero_frac, out_valid_r && (out_angle_fraction_r == '0), out_weighted_energy_r == '0, "zero fraction with nonzero energy")

endmodule
